// File: rtl/core/aesc_pkg.sv
// Shared types and constants for the terminal escape parser core.
// No dependencies; imported by every other file in rtl/core except aesc_fifo.
package aesc_pkg;

  localparam int BYTE_W   = 8;
  localparam int COORD_W  = 16;
  localparam int COLOUR_W = 16;
  localparam int PARAM_W  = 12;
  localparam int GLYPH_W  = 7;
  localparam int CMD_W    = 3;

  localparam logic [PARAM_W-1:0] PARAM_SAT = 12'd3276;

  // Result command codes
  localparam logic [CMD_W-1:0] CMD_GLYPH     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR_ROW = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR_SCR = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SCROLL    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_COLOURS   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_MOVE      = 3'd5;

  // Received characters of interest
  localparam logic [BYTE_W-1:0] CHAR_BS    = 8'h08;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_VT    = 8'h0B;
  localparam logic [BYTE_W-1:0] CHAR_FF    = 8'h0C;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_ESC   = 8'h1B;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CHAR_SEMI  = 8'h3B;
  localparam logic [BYTE_W-1:0] CHAR_AT    = 8'h40;
  localparam logic [BYTE_W-1:0] CHAR_UP    = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_DOWN  = 8'h42;
  localparam logic [BYTE_W-1:0] CHAR_RIGHT = 8'h43;
  localparam logic [BYTE_W-1:0] CHAR_LEFT  = 8'h44;
  localparam logic [BYTE_W-1:0] CHAR_SU    = 8'h53;
  localparam logic [BYTE_W-1:0] CHAR_SD    = 8'h54;
  localparam logic [BYTE_W-1:0] CHAR_SGR   = 8'h6D;
  localparam logic [BYTE_W-1:0] CHAR_TILDE = 8'h7E;

  localparam logic [COORD_W-1:0] LINE_PX  = 16'd10;
  localparam logic [COORD_W-1:0] CHAR_PX  = 16'd6;
  localparam logic [GLYPH_W-1:0] BLANK    = 7'd32;

  localparam logic [PARAM_W-1:0] SGR_FG_LO = 12'd30;
  localparam logic [PARAM_W-1:0] SGR_FG_HI = 12'd37;
  localparam logic [PARAM_W-1:0] SGR_BG_LO = 12'd40;
  localparam logic [PARAM_W-1:0] SGR_BG_HI = 12'd47;

  localparam logic [COLOUR_W-1:0] COLOUR_WHITE  = 16'hFFFF;
  localparam logic [COLOUR_W-1:0] COLOUR_BLACK  = 16'h0000;
  localparam logic [COLOUR_W-1:0] COLOUR_DIM    = 16'h0800;
  localparam logic [COLOUR_W-1:0] COLOUR_TAB [8] = '{
    16'h0000, 16'hF800, 16'h07E0, 16'hFFE0, 16'h001F, 16'hF81F, 16'h07FF, 16'hFFFF
  };

  // Decoded operation codes passed from front to back
  typedef logic [3:0] op_code_t;
  localparam op_code_t OP_CR       = 4'd0;
  localparam op_code_t OP_LF       = 4'd1;
  localparam op_code_t OP_VT       = 4'd2;
  localparam op_code_t OP_BS       = 4'd3;
  localparam op_code_t OP_FF       = 4'd4;
  localparam op_code_t OP_GLYPH    = 4'd5;
  localparam op_code_t OP_SGR      = 4'd6;
  localparam op_code_t OP_MOVE_ROW = 4'd7;
  localparam op_code_t OP_MOVE_COL = 4'd8;
  localparam op_code_t OP_SCROLL   = 4'd9;

  // Colour action of an SGR final
  typedef logic [1:0] sgr_act_t;
  localparam sgr_act_t SGR_KEEP  = 2'd0;
  localparam sgr_act_t SGR_RESET = 2'd1;
  localparam sgr_act_t SGR_FORE  = 2'd2;
  localparam sgr_act_t SGR_BACK  = 2'd3;

  typedef struct packed {
    op_code_t             code;
    logic [GLYPH_W-1:0]   glyph;
    sgr_act_t             sgr;
    logic [COORD_W-1:0]   arg;   // signed delta, scroll amount or colour
  } op_t;

  typedef struct packed {
    logic [CMD_W-1:0]     command;
    logic [COORD_W-1:0]   pos_x;
    logic [COORD_W-1:0]   pos_y;
    logic [GLYPH_W-1:0]   glyph;
    logic [COLOUR_W-1:0]  fore_colour;
    logic [COLOUR_W-1:0]  back_colour;
    logic [COORD_W-1:0]   scroll_amount;
    logic                 last;
  } result_t;

endpackage

// File: rtl/core/aesc_fifo.sv
// Small register FIFO used for the op queue and the result queue.
// No package dependency.
module aesc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + AW'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + AW'(1);
    end
    unique case ({wr_en, rd_en})
      2'b10:   count_nxt = count_r + CNT_ONE;
      2'b01:   count_nxt = count_r - CNT_ONE;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: rtl/core/aesc_front.sv
// Front end: escape-sequence parser and byte classifier.
// Uses aesc_pkg; produces aesc_pkg::op_t entries for the op queue.
module aesc_front #(
  parameter int MAX_PARAMS = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 take,
  input  logic [7:0]           rx_byte,
  output logic                 op_wr,
  output aesc_pkg::op_t        op
);
  import aesc_pkg::*;

  localparam int FIELD_W = $clog2(MAX_PARAMS + 2);
  localparam logic [FIELD_W-1:0] FIELD_IDLE = '0;
  localparam logic [FIELD_W-1:0] FIELD_ONE  = FIELD_W'(1);
  localparam logic [FIELD_W-1:0] K_MAX      = FIELD_W'(MAX_PARAMS);
  localparam bit HAS_SECOND = (MAX_PARAMS > 1);

  logic [FIELD_W-1:0]  field_r, field_nxt;
  logic [PARAM_W-1:0]  p1_r, p1_nxt;
  logic [PARAM_W-1:0]  p2_r, p2_nxt;

  logic [FIELD_W-1:0]  k;
  logic [PARAM_W-1:0]  cur_p;
  logic [15:0]         acc;
  logic [PARAM_W-1:0]  acc_sat;
  logic [15:0]         p10;
  logic [15:0]         p6;
  logic [PARAM_W-1:0]  fg_off;
  logic [PARAM_W-1:0]  bg_off;
  logic                bright;
  logic                op_vld;

  assign k      = field_r - FIELD_ONE;
  assign cur_p  = (k == FIELD_IDLE) ? p1_r : p2_r;
  assign acc    = ({4'b0, cur_p} << 3) + ({4'b0, cur_p} << 1) + {12'b0, rx_byte[3:0]};
  assign acc_sat = (acc > {4'b0, PARAM_SAT}) ? PARAM_SAT : acc[PARAM_W-1:0];
  assign p10    = ({4'b0, p1_r} << 3) + ({4'b0, p1_r} << 1);
  assign p6     = ({4'b0, p1_r} << 2) + ({4'b0, p1_r} << 1);
  assign fg_off = p2_r - SGR_FG_LO;
  assign bg_off = p2_r - SGR_BG_LO;
  assign bright = (p1_r != '0);
  assign op_wr  = take && op_vld;

  always_comb begin
    field_nxt = field_r;
    p1_nxt    = p1_r;
    p2_nxt    = p2_r;
    op_vld    = 1'b0;
    op        = '0;
    if (!rx_byte[7]) begin
      if (field_r == FIELD_IDLE) begin
        op_vld = 1'b1;
        unique case (rx_byte)
          CHAR_CR:  op.code = OP_CR;
          CHAR_LF:  op.code = OP_LF;
          CHAR_VT:  op.code = OP_VT;
          CHAR_BS:  op.code = OP_BS;
          CHAR_FF:  op.code = OP_FF;
          CHAR_ESC: begin
            op_vld    = 1'b0;
            field_nxt = FIELD_ONE;
          end
          default: begin
            op.code  = OP_GLYPH;
            op.glyph = rx_byte[6:0];
          end
        endcase
      end else begin
        priority if (rx_byte >= CHAR_ZERO && rx_byte <= CHAR_NINE) begin
          if (k == FIELD_IDLE) begin
            p1_nxt = acc_sat;
          end else if (HAS_SECOND && k == FIELD_ONE) begin
            p2_nxt = acc_sat;
          end
        end else if (rx_byte == CHAR_SEMI) begin
          if (k < K_MAX) begin
            field_nxt = field_r + FIELD_ONE;
          end
        end else if (rx_byte > CHAR_AT && rx_byte < CHAR_TILDE) begin
          // Any final byte closes the sequence, overflow included
          field_nxt = FIELD_IDLE;
          p1_nxt    = '0;
          p2_nxt    = '0;
          op_vld    = 1'b1;
          unique case (rx_byte)
            CHAR_SGR: begin
              op.code = OP_SGR;
              if (k == FIELD_ONE) begin
                if (p2_r == '0) begin
                  op.sgr = SGR_RESET;
                end else if (p2_r >= SGR_FG_LO && p2_r <= SGR_FG_HI) begin
                  op.sgr = SGR_FORE;
                  op.arg = (bright && p2_r == SGR_FG_LO) ? COLOUR_DIM
                                                         : COLOUR_TAB[fg_off[2:0]];
                end else if (p2_r >= SGR_BG_LO && p2_r <= SGR_BG_HI) begin
                  op.sgr = SGR_BACK;
                  op.arg = (bright && p2_r == SGR_BG_LO) ? COLOUR_DIM
                                                         : COLOUR_TAB[bg_off[2:0]];
                end
              end else if (k == FIELD_IDLE && !bright) begin
                op.sgr = SGR_RESET;
              end
            end
            CHAR_UP: begin
              op.code = OP_MOVE_ROW;
              op.arg  = 16'd0 - p10;
            end
            CHAR_DOWN: begin
              op.code = OP_MOVE_ROW;
              op.arg  = p10;
            end
            CHAR_RIGHT: begin
              op.code = OP_MOVE_COL;
              op.arg  = p6;
            end
            CHAR_LEFT: begin
              op.code = OP_MOVE_COL;
              op.arg  = 16'd0 - p6;
            end
            CHAR_SU: begin
              op.code = OP_SCROLL;
              op.arg  = p10;
            end
            CHAR_SD: begin
              op.code = OP_SCROLL;
              op.arg  = 16'd0 - p10;
            end
            default: op_vld = 1'b0;
          endcase
        end else begin
          op_vld = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_r <= FIELD_IDLE;
      p1_r    <= '0;
      p2_r    <= '0;
    end else if (take) begin
      field_r <= field_nxt;
      p1_r    <= p1_nxt;
      p2_r    <= p2_nxt;
    end
  end

endmodule

// File: rtl/core/aesc_back.sv
// Back end: executes decoded ops on cursor and colour state, builds results.
// Uses aesc_pkg; reads the op queue head, writes the result queue.
module aesc_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  op_valid,
  input  aesc_pkg::op_t         op,
  input  logic                  res_space,
  input  logic [9:0]            screen_height,
  output logic                  op_pop,
  output logic                  res_wr,
  output aesc_pkg::result_t     res
);
  import aesc_pkg::*;

  logic [COORD_W-1:0]  col_r, col_nxt;
  logic [COORD_W-1:0]  row_r, row_nxt;
  logic [COLOUR_W-1:0] fore_r, fore_nxt;
  logic [COLOUR_W-1:0] back_r, back_nxt;
  logic                bs_phase_r;
  logic                go;
  logic                wrap;

  assign go     = op_valid && res_space;
  assign res_wr = go;
  assign op_pop = go && (op.code != OP_BS || bs_phase_r);
  // Bottom wrap test, signed cursor row against height minus one line
  assign wrap   = $signed({row_r[15], row_r}) >= ($signed({7'b0, screen_height}) - 17'sd10);

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    fore_nxt = fore_r;
    back_nxt = back_r;
    res      = '0;
    res.last = 1'b1;
    unique case (op.code)
      OP_CR: begin
        col_nxt     = '0;
        res.command = CMD_MOVE;
        res.pos_y   = row_r;
      end
      OP_LF: begin
        col_nxt     = '0;
        row_nxt     = row_r + LINE_PX;
        res.command = CMD_CLEAR_ROW;
        res.pos_y   = row_nxt;
      end
      OP_VT: begin
        col_nxt     = '0;
        row_nxt     = row_r - LINE_PX;
        res.command = CMD_MOVE;
        res.pos_y   = row_nxt;
      end
      OP_BS: begin
        res.command = CMD_GLYPH;
        res.glyph   = BLANK;
        res.pos_y   = row_r;
        if (bs_phase_r) begin
          col_nxt   = col_r - CHAR_PX;
          res.pos_x = col_nxt;
        end else begin
          res.pos_x = col_r;
          res.last  = 1'b0;
        end
      end
      OP_FF: begin
        col_nxt     = '0;
        row_nxt     = '0;
        res.command = CMD_CLEAR_SCR;
      end
      OP_GLYPH: begin
        if (wrap) begin
          row_nxt = '0;
        end
        col_nxt     = col_r + CHAR_PX;
        res.command = CMD_GLYPH;
        res.pos_x   = col_r;
        res.pos_y   = row_nxt;
        res.glyph   = op.glyph;
      end
      OP_SGR: begin
        unique case (op.sgr)
          SGR_RESET: begin
            fore_nxt = COLOUR_WHITE;
            back_nxt = COLOUR_BLACK;
          end
          SGR_FORE: fore_nxt = op.arg;
          SGR_BACK: back_nxt = op.arg;
          default:  fore_nxt = fore_r;
        endcase
        res.command = CMD_COLOURS;
      end
      OP_MOVE_ROW: begin
        row_nxt     = row_r + op.arg;
        res.command = CMD_MOVE;
        res.pos_x   = col_r;
        res.pos_y   = row_nxt;
      end
      OP_MOVE_COL: begin
        col_nxt     = col_r + op.arg;
        res.command = CMD_MOVE;
        res.pos_x   = col_nxt;
        res.pos_y   = row_r;
      end
      OP_SCROLL: begin
        res.command       = CMD_SCROLL;
        res.pos_x         = col_r;
        res.pos_y         = row_r;
        res.scroll_amount = op.arg;
      end
      default: res.command = CMD_MOVE;
    endcase
    res.fore_colour = fore_nxt;
    res.back_colour = back_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      fore_r     <= COLOUR_WHITE;
      back_r     <= COLOUR_BLACK;
      bs_phase_r <= 1'b0;
    end else if (go) begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      fore_r     <= fore_nxt;
      back_r     <= back_nxt;
      bs_phase_r <= (op.code == OP_BS) && !bs_phase_r;
    end
  end

endmodule

// File: rtl/core/ansi_terminal_escape_parser_core.sv
// Top level of the terminal escape parser core: front parser, op queue,
// back executor, result queue. Uses aesc_pkg, aesc_front, aesc_fifo, aesc_back.
//
//  channel   dir  handshake          payload
//  -------   ---  -----------------  -------------------------------------------
//  input     in   push / full        in_rx_byte[7:0]
//  result    out  empty / pop        out_command .. out_last (8 fields)
//  config    in   cfg_we             cfg_wdata[9:0] = screen height in pixels
//
// Flow: a byte is taken every cycle while the op queue has room; the
// back end retires one result per cycle while the result queue has space,
// so a backspace yields two results and every other byte one or none.
// Reset (rst_n low, synchronous) empties both queues, idles the parser and
// homes the cursor with white-on-black colours; screen height returns to 320.
// Stalls: a held pop fills the result queue, then the op queue, then full rises.
module ansi_terminal_escape_parser_core #(
  parameter int MAX_PARAMS = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  // input transactions
  input  logic               push,
  output logic               full,
  input  logic [7:0]         in_rx_byte,
  // result transactions
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         out_command,
  output logic signed [15:0] out_pos_x,
  output logic signed [15:0] out_pos_y,
  output logic [6:0]         out_glyph,
  output logic [15:0]        out_fore_colour,
  output logic [15:0]        out_back_colour,
  output logic signed [15:0] out_scroll_amount,
  output logic               out_last,
  // configuration
  input  logic               cfg_we,
  input  logic [9:0]         cfg_wdata
);
  import aesc_pkg::*;

  localparam int QUEUE_DEPTH = 2;
  localparam logic [9:0] HEIGHT_RESET = 10'd320;

  logic [9:0] screen_height_r;

  logic       take;
  logic       op_wr;
  op_t        op_in;
  logic       op_full;
  logic       op_empty;
  op_t        op_head;
  logic       op_pop;

  logic       res_wr;
  result_t    res_in;
  logic       res_full;
  logic       res_empty;
  result_t    res_head;
  logic       res_pop;
  logic       res_space;

  // Input transaction accepted whenever the op queue has a free slot,
  // even for bytes that the parser swallows.
  assign full  = op_full;
  assign take  = push && !op_full;

  // Result slot frees in the same cycle as a pop, keeping one result per cycle.
  assign res_pop   = pop && !res_empty;
  assign res_space = !res_full || res_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      screen_height_r <= cfg_wdata;
    end
  end

  aesc_front #(
    .MAX_PARAMS (MAX_PARAMS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .rx_byte (in_rx_byte),
    .op_wr   (op_wr),
    .op      (op_in)
  );

  aesc_fifo #(
    .WIDTH ($bits(op_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_opq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (op_wr),
    .wr_data (op_in),
    .full    (op_full),
    .rd_en   (op_pop),
    .rd_data (op_head),
    .empty   (op_empty)
  );

  aesc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .op_valid      (!op_empty),
    .op            (op_head),
    .res_space     (res_space),
    .screen_height (screen_height_r),
    .op_pop        (op_pop),
    .res_wr        (res_wr),
    .res           (res_in)
  );

  aesc_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_resq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_wr),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (res_pop),
    .rd_data (res_head),
    .empty   (res_empty)
  );

  assign empty             = res_empty;
  assign out_command       = res_head.command;
  assign out_pos_x         = $signed(res_head.pos_x);
  assign out_pos_y         = $signed(res_head.pos_y);
  assign out_glyph         = res_head.glyph;
  assign out_fore_colour   = res_head.fore_colour;
  assign out_back_colour   = res_head.back_colour;
  assign out_scroll_amount = $signed(res_head.scroll_amount);
  assign out_last          = res_head.last;

endmodule

// File: rtl/core/aesc_checker.sv
// Port-level checks for the terminal escape parser core, bound to the top.
// Uses aesc_pkg command codes.
module aesc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               empty,
  input logic               pop,
  input logic [2:0]         out_command,
  input logic signed [15:0] out_pos_x,
  input logic signed [15:0] out_pos_y,
  input logic [6:0]         out_glyph,
  input logic signed [15:0] out_scroll_amount,
  input logic               out_last
);
  import aesc_pkg::*;

  // Reset leaves no stale result behind
  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  // A result not taken stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_command) && $stable(out_pos_x)
                          && $stable(out_pos_y) && $stable(out_last)))
    else $error("waiting result changed");

  // Clear screen and colour updates are anchored at the origin
  a_origin: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_command == CMD_CLEAR_SCR || out_command == CMD_COLOURS))
      |-> (out_pos_x == 16'sd0 && out_pos_y == 16'sd0))
    else $error("clear screen or colour command with nonzero position");

  // Glyph code and scroll distance only travel with their own commands, and the command code is a defined one
  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> ((out_command == CMD_GLYPH || out_glyph == 7'd0)
                && (out_command == CMD_SCROLL || out_scroll_amount == 16'sd0)
                && out_command <= CMD_MOVE))
    else $error("unused result field nonzero or bad command");

endmodule

bind ansi_terminal_escape_parser_core aesc_checker u_aesc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .empty             (empty),
  .pop               (pop),
  .out_command       (out_command),
  .out_pos_x         (out_pos_x),
  .out_pos_y         (out_pos_y),
  .out_glyph         (out_glyph),
  .out_scroll_amount (out_scroll_amount),
  .out_last          (out_last)
);
